// ----- hdl/h20_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// h20_pkg
// shared types, constants and tables of the 20-node hexahedron evaluator
// ----------------------------------------------------------------------------
package h20_pkg;

	localparam int NODE_COUNT   = 20;
	localparam int CORNER_COUNT = 8;
	localparam int NODE_W       = 5;
	localparam int COORD_W      = 16;
	localparam int OUT_W        = 17;

	// position of a node along one axis
	typedef enum logic [1:0] {
		AX_LO,
		AX_HI,
		AX_MID
	} axis_t;

	typedef logic [NODE_W-1:0] node_t;

	// width that holds every axis factor and derivative factor
	function automatic int factor_width(input int frac);
		int m;
		m = ((frac > 15) ? frac : 15) + 1;
		return 2 * m - frac + 2;
	endfunction

	// axis positions of a node, ordered r, s, t
	function automatic logic [5:0] node_axes(input node_t n);
		logic [5:0] p;
		case (n)
			5'd0:    p = {AX_LO,  AX_LO,  AX_LO};
			5'd1:    p = {AX_HI,  AX_LO,  AX_LO};
			5'd2:    p = {AX_HI,  AX_HI,  AX_LO};
			5'd3:    p = {AX_LO,  AX_HI,  AX_LO};
			5'd4:    p = {AX_LO,  AX_LO,  AX_HI};
			5'd5:    p = {AX_HI,  AX_LO,  AX_HI};
			5'd6:    p = {AX_HI,  AX_HI,  AX_HI};
			5'd7:    p = {AX_LO,  AX_HI,  AX_HI};
			5'd8:    p = {AX_MID, AX_LO,  AX_LO};
			5'd9:    p = {AX_HI,  AX_MID, AX_LO};
			5'd10:   p = {AX_MID, AX_HI,  AX_LO};
			5'd11:   p = {AX_LO,  AX_MID, AX_LO};
			5'd12:   p = {AX_MID, AX_LO,  AX_HI};
			5'd13:   p = {AX_HI,  AX_MID, AX_HI};
			5'd14:   p = {AX_MID, AX_HI,  AX_HI};
			5'd15:   p = {AX_LO,  AX_MID, AX_HI};
			5'd16:   p = {AX_LO,  AX_LO,  AX_MID};
			5'd17:   p = {AX_HI,  AX_LO,  AX_MID};
			5'd18:   p = {AX_HI,  AX_HI,  AX_MID};
			5'd19:   p = {AX_LO,  AX_HI,  AX_MID};
			default: p = {AX_MID, AX_MID, AX_MID};
		endcase
		return p;
	endfunction

	// three mid-edge neighbors of a corner
	function automatic logic [3*NODE_W-1:0] corner_edges(input node_t n);
		logic [3*NODE_W-1:0] e;
		case (n)
			5'd0:    e = {5'd8,  5'd11, 5'd16};
			5'd1:    e = {5'd8,  5'd9,  5'd17};
			5'd2:    e = {5'd9,  5'd10, 5'd18};
			5'd3:    e = {5'd10, 5'd11, 5'd19};
			5'd4:    e = {5'd12, 5'd15, 5'd16};
			5'd5:    e = {5'd12, 5'd13, 5'd17};
			5'd6:    e = {5'd13, 5'd14, 5'd18};
			5'd7:    e = {5'd14, 5'd15, 5'd19};
			default: e = {5'd8,  5'd8,  5'd8};
		endcase
		return e;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/h20_node_eval.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// h20_node_eval
// three-stage evaluator of one node's value and three derivatives
// ----------------------------------------------------------------------------
module h20_node_eval
	import h20_pkg::*;
#(
	parameter int FRAC_BITS = 14
) (
	input  wire                    clk,
	input  wire node_t             node,
	input  wire [COORD_W-1:0]      coord_r,
	input  wire [COORD_W-1:0]      coord_s,
	input  wire [COORD_W-1:0]      coord_t,
	output logic signed [3*factor_width(FRAC_BITS)-2*FRAC_BITS:0] quant [4]
);

	localparam int GW  = factor_width(FRAC_BITS);
	localparam int MW  = 2 * GW + 1;
	localparam int P1W = 2 * GW - FRAC_BITS + 1;
	localparam int QW  = 3 * GW - 2 * FRAC_BITS + 1;
	localparam int PW  = P1W + GW + 1;

	logic signed [GW-1:0] f_s1 [3];
	logic signed [GW-1:0] df_s1 [3];
	logic [1:0]           k_s1;
	logic signed [P1W-1:0] p1_s2 [4];
	logic signed [GW-1:0]  c_s2 [4];
	logic [1:0]            k_s2;

	logic signed [GW-1:0] f_c [3];
	logic signed [GW-1:0] df_c [3];
	logic [1:0]           k_c;
	logic signed [P1W-1:0] p1_c [4];
	logic signed [GW-1:0]  c_c [4];
	logic signed [QW-1:0]  q_c [4];

	// stage 1: axis factors
	always_comb begin
		logic [5:0] axes;
		logic signed [GW-1:0] x, one, plus, minus;
		logic signed [MW-1:0] mid;
		logic [COORD_W-1:0] cin;
		axes = node_axes(node);
		one  = GW'(1) <<< FRAC_BITS;
		k_c  = 2'd0;
		for (int d = 0; d < 3; d++) begin
			cin   = (d == 0) ? coord_r : ((d == 1) ? coord_s : coord_t);
			x     = GW'($signed(cin));
			plus  = one + x;
			minus = one - x;
			mid   = MW'(plus) * MW'(minus);
			mid   = (mid + (MW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
			unique case (axis_t'(axes[4-2*d +: 2]))
				AX_HI: begin
					f_c[d]  = plus;
					df_c[d] = one;
					k_c     = k_c + 2'd1;
				end
				AX_LO: begin
					f_c[d]  = minus;
					df_c[d] = -one;
					k_c     = k_c + 2'd1;
				end
				default: begin
					f_c[d]  = mid[GW-1:0];
					df_c[d] = -(x <<< 1);
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		f_s1  <= f_c;
		df_s1 <= df_c;
		k_s1  <= k_c;
	end

	// stage 2: first product, rounded by the fraction bits
	always_comb begin
		logic signed [GW-1:0] a, b;
		logic signed [MW-1:0] p;
		for (int j = 0; j < 4; j++) begin
			a = (j == 1) ? df_s1[0] : f_s1[0];
			b = (j == 2) ? df_s1[1] : f_s1[1];
			c_c[j] = (j == 3) ? df_s1[2] : f_s1[2];
			p = MW'(a) * MW'(b);
			p = (p + (MW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
			p1_c[j] = p[P1W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		p1_s2 <= p1_c;
		c_s2  <= c_c;
		k_s2  <= k_s1;
	end

	// stage 3: second product, rounded by fraction bits plus weight shift
	always_comb begin
		logic signed [PW-1:0] p, half;
		half = PW'(1) <<< (FRAC_BITS - 1 + int'(k_s2));
		for (int j = 0; j < 4; j++) begin
			p = PW'(p1_s2[j]) * PW'(c_s2[j]);
			p = (p + half) >>> (FRAC_BITS + int'(k_s2));
			q_c[j] = p[QW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		quant <= q_c;
	end

endmodule
`default_nettype wire

// ----- hdl/hex20_shape_function_eval.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hex20_shape_function_eval
// shape values and local derivatives of a 20-node serendipity hexahedron
// ----------------------------------------------------------------------------
// A point (coord_r, coord_s, coord_t) is taken when start is high and busy is
// low. It yields twenty result words, nodes 0..19 in order, one per cycle on
// consecutive cycles, each marked by result_valid for one cycle; last_node
// flags node 19. The node sequencer issues one node per cycle, and a new
// point can be taken in the cycle that issues node 19 of the previous one, so
// points can follow back to back with the output never idle. On its way to
// the ports a word passes the node counter, the evaluator stage registers and
// the corrected-result register. The receiver cannot stall the block.
// ----------------------------------------------------------------------------
module hex20_shape_function_eval
	import h20_pkg::*;
#(
	parameter int FRAC_BITS = 14
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	output logic                     busy,
	input  wire signed [COORD_W-1:0] coord_r,
	input  wire signed [COORD_W-1:0] coord_s,
	input  wire signed [COORD_W-1:0] coord_t,
	output logic                     result_valid,
	output logic [NODE_W-1:0]        node_index,
	output logic signed [OUT_W-1:0]  shape_value,
	output logic signed [OUT_W-1:0]  deriv_r,
	output logic signed [OUT_W-1:0]  deriv_s,
	output logic signed [OUT_W-1:0]  deriv_t,
	output logic                     last_node
);

	localparam int GW = factor_width(FRAC_BITS);
	localparam int QW = 3 * GW - 2 * FRAC_BITS + 1;
	localparam int CW = QW + 2;
	localparam node_t LAST = node_t'(NODE_COUNT - 1);
	localparam logic signed [CW-1:0] SAT_HI = CW'((1 << (OUT_W - 1)) - 1);
	localparam logic signed [CW-1:0] SAT_LO = -CW'(1 << (OUT_W - 1));

	// sequencer
	logic               busy_q;
	node_t              cnt_q;
	logic [COORD_W-1:0] r_q, s_q, t_q;
	logic               accept;

	// pipeline control
	logic  v_s1, v_s2, v_s3, v_s4;
	node_t node_s1, node_s2, node_s3, node_s4;

	// lane 0 is the issued node, lanes 1..3 the adjacent edges of a corner
	node_t                 lane_node [4];
	logic signed [QW-1:0]  lane_q [4][4];
	logic signed [OUT_W-1:0] res_c [4];
	logic signed [OUT_W-1:0] res_s4 [4];

	assign busy   = busy_q && (cnt_q != LAST);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			busy_q <= (cnt_q != LAST);
			cnt_q  <= cnt_q + node_t'(1);
		end
	end

	// coordinates held for the whole run of twenty nodes
	always_ff @(posedge clk) begin
		if (accept) begin
			r_q <= coord_r;
			s_q <= coord_s;
			t_q <= coord_t;
		end
	end

	always_comb begin
		logic [3*NODE_W-1:0] edges;
		edges        = corner_edges(cnt_q);
		lane_node[0] = cnt_q;
		lane_node[1] = edges[3*NODE_W-1 -: NODE_W];
		lane_node[2] = edges[2*NODE_W-1 -: NODE_W];
		lane_node[3] = edges[NODE_W-1:0];
	end

	for (genvar l = 0; l < 4; l++) begin : g_lane
		h20_node_eval #(
			.FRAC_BITS (FRAC_BITS)
		) u_eval (
			.clk     (clk),
			.node    (lane_node[l]),
			.coord_r (r_q),
			.coord_s (s_q),
			.coord_t (t_q),
			.quant   (lane_q[l])
		);
	end

	// valid bits and node numbers move alongside the evaluator stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= busy_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		node_s1 <= cnt_q;
		node_s2 <= node_s1;
		node_s3 <= node_s2;
		node_s4 <= node_s3;
	end

	// stage 4: corner correction by half the edge sum, then saturation
	always_comb begin
		logic signed [CW-1:0] sum, corr, v;
		for (int j = 0; j < 4; j++) begin
			sum  = CW'(lane_q[1][j]) + CW'(lane_q[2][j]) + CW'(lane_q[3][j]);
			corr = (sum + CW'(1)) >>> 1;
			v    = CW'(lane_q[0][j]);
			if (node_s3 < node_t'(CORNER_COUNT)) begin
				v = v - corr;
			end
			if (v > SAT_HI) begin
				res_c[j] = SAT_HI[OUT_W-1:0];
			end else if (v < SAT_LO) begin
				res_c[j] = SAT_LO[OUT_W-1:0];
			end else begin
				res_c[j] = v[OUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		res_s4 <= res_c;
	end

	assign result_valid = v_s4;
	assign node_index   = node_s4;
	assign shape_value  = res_s4[0];
	assign deriv_r      = res_s4[1];
	assign deriv_s      = res_s4[2];
	assign deriv_t      = res_s4[3];
	assign last_node    = v_s4 && (node_s4 == LAST);

	// a run's words come out on consecutive cycles with rising node numbers
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_node |=>
			result_valid && (node_index == $past(node_index) + node_t'(1)))
		else $error("node run broken");

	// a taken point later shows node 0 at the output
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##5 result_valid && (node_index == '0))
		else $error("first node missing");

	// every issued node reaches the output
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ##4 result_valid)
		else $error("issued node lost");

endmodule
`default_nettype wire
